// ===== hw/rtl/srs_pkg.sv =====
// Shared types and constants for the sequence-numbered ring store.
`default_nettype none

package srs_pkg;

    localparam int SLOTS    = 16;
    localparam int DATA_W   = 32;
    localparam int TAG_W    = 32;
    localparam int IO_W     = 32;
    localparam int OIDX_W   = 4;
    localparam int CFG_W    = 5;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int NCMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IDXX_W   = (IDX_W > OIDX_W) ? IDX_W : OIDX_W;
    localparam int DATAX_W  = (DATA_W > IO_W) ? DATA_W : IO_W;

    localparam logic [TAG_W-1:0] ERASED_TAG  = '1;
    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    // Running scan result handed from cell to cell
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [TAG_W-1:0] best;
        logic [IDX_W-1:0] at;
        logic             found;
    } scan_rec_t;

    // Tag write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
    } tag_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srs_cell.sv =====
// One ring slot tag plus one step of the newest/oldest scan.
`default_nettype none

module srs_cell
    import srs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire logic [CNT_W-1:0] n_eff,
    input  wire scan_rec_t        rec_i,
    output scan_rec_t             rec_o,
    input  wire tag_wr_t          wr
);

    logic [TAG_W-1:0] tag_reg;
    scan_rec_t        rec_reg;
    scan_rec_t        rec_next;
    logic             in_use;
    logic             better;
    logic             hit;

    assign in_use = CNT_W'(my_idx) < n_eff;
    // ties go to the later slot on both scans
    assign better = (rec_i.op == OP_GET) ? (tag_reg <= rec_i.best) : (tag_reg >= rec_i.best);
    assign hit    = rec_i.valid && in_use && (tag_reg != ERASED_TAG) && better;

    always_comb begin
        rec_next = rec_i;
        if (hit) begin
            rec_next.best  = tag_reg;
            rec_next.at    = my_idx;
            rec_next.found = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.valid <= 1'b0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= ERASED_TAG;
        end else if (wr.en && (wr.idx == my_idx)) begin
            tag_reg <= wr.tag;
        end
    end

    assign rec_o = rec_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_chain.sv =====
// Row of slot cells; the scan record moves one cell per clock.
`default_nettype none

module srs_chain
    import srs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CNT_W-1:0] n_eff,
    input  wire scan_rec_t        rec_i,
    output scan_rec_t             rec_o,
    input  wire tag_wr_t          wr
);

    scan_rec_t link [SLOTS+1];

    assign link[0] = rec_i;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        srs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .my_idx  (IDX_W'(i)),
            .n_eff   (n_eff),
            .rec_i   (link[i]),
            .rec_o   (link[i+1]),
            .wr      (wr)
        );
    end

    assign rec_o = link[SLOTS];

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_numbered_ring_store.sv =====
// Top level: control, slot data memory and result register around the cell row.
//
//   channel   ports                                         direction
//   input     s_valid s_ready s_mode s_data_in               in
//   result    m_valid m_ready m_data_out m_slot_index m_tag  out
//             m_was_empty
//   config    cfg_valid cfg_ready cfg_slots_in_use           in
//
// Each transaction passes from accept through the launch register, the row of cell registers,
// the EMIT state and the output register to result valid; the scan record walks the row of cells one slot per cycle.
// s_ready is high only in idle, so a new transaction is not accepted until the last one is back in idle;
// cfg_ready is always high.
// Reset erases all slot tags and sets slots_in_use to 16; slot data is not cleared.
// A stalled result holds in the output register; the next transaction scans, then
// waits with its result and holds s_ready low until the output register frees.
`default_nettype none

module sequence_numbered_ring_store
    import srs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    input  wire logic [IO_W-1:0]   s_data_in,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IO_W-1:0]        m_data_out,
    output logic [OIDX_W-1:0]      m_slot_index,
    output logic [TAG_W-1:0]       m_tag,
    output logic                   m_was_empty,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_slots_in_use
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  slots_in_use_reg;
    logic [DATA_W-1:0] din_reg;
    scan_rec_t         launch_reg;
    scan_rec_t         chain_out;
    tag_wr_t           wr;

    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [TAG_W-1:0]  res_tag_reg, res_tag_next;
    logic              res_empty_reg, res_empty_next;
    logic              res_rd_reg, res_rd_next;

    logic [DATA_W-1:0] mem [SLOTS];
    logic [DATA_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    logic              m_valid_reg, m_valid_next;
    logic [IO_W-1:0]   m_data_out_reg;
    logic [OIDX_W-1:0] m_slot_index_reg;
    logic [TAG_W-1:0]  m_tag_reg;
    logic              m_was_empty_reg;

    logic [NCMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0]  n_eff;
    logic              s_accept;
    logic              load_out;
    logic [IDX_W-1:0]  put_idx;
    logic [TAG_W-1:0]  put_tag;

    // slot count clamped to 1 .. SLOTS
    assign cfg_ext = NCMP_W'(slots_in_use_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (cfg_ext > NCMP_W'(SLOTS)) begin
            n_eff = CNT_W'(SLOTS);
        end else begin
            n_eff = CNT_W'(cfg_ext);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign load_out  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            slots_in_use_reg <= cfg_slots_in_use;
        end
    end

    srs_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_eff   (n_eff),
        .rec_i   (launch_reg),
        .rec_o   (chain_out),
        .wr      (wr)
    );

    // put target: slot after the newest, wrapping at the slot count
    assign put_idx = (CNT_W'(chain_out.at) + CNT_W'(1) == n_eff) ? '0
                   : chain_out.at + IDX_W'(1);
    assign put_tag = chain_out.found ? chain_out.best + TAG_W'(1) : '0;

    always_comb begin
        state_next     = state_reg;
        res_idx_next   = res_idx_reg;
        res_tag_next   = res_tag_reg;
        res_empty_next = res_empty_reg;
        res_rd_next    = res_rd_reg;
        wr             = '0;
        mem_we         = 1'b0;
        mem_waddr      = put_idx;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chain_out.valid) begin
                    state_next = ST_EMIT;
                    if (chain_out.op == OP_PUT) begin
                        wr.en          = 1'b1;
                        wr.idx         = put_idx;
                        wr.tag         = put_tag;
                        mem_we         = 1'b1;
                        res_idx_next   = put_idx;
                        res_tag_next   = put_tag;
                        res_empty_next = 1'b0;
                        res_rd_next    = 1'b0;
                    end else if (chain_out.found) begin
                        wr.en          = 1'b1;
                        wr.idx         = chain_out.at;
                        wr.tag         = ERASED_TAG;
                        res_idx_next   = chain_out.at;
                        res_tag_next   = chain_out.best;
                        res_empty_next = 1'b0;
                        res_rd_next    = 1'b1;
                    end else begin
                        res_idx_next   = '0;
                        res_tag_next   = '0;
                        res_empty_next = 1'b1;
                        res_rd_next    = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            launch_reg.valid <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            launch_reg.valid <= s_accept;
            m_valid_reg      <= m_valid_next;
            if (s_accept) begin
                launch_reg.op    <= op_t'(s_mode);
                launch_reg.best  <= (op_t'(s_mode) == OP_GET) ? ERASED_TAG : '0;
                launch_reg.at    <= '0;
                launch_reg.found <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            din_reg <= DATA_W'(s_data_in);
        end
        res_idx_reg   <= res_idx_next;
        res_tag_reg   <= res_tag_next;
        res_empty_reg <= res_empty_next;
        res_rd_reg    <= res_rd_next;
    end

    // slot data memory: one write port, one registered read port held until emitted
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= din_reg;
        end
        if ((state_reg == ST_SCAN) && chain_out.valid) begin
            mem_q_reg <= mem[chain_out.at];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_out_reg   <= res_rd_reg ? IO_W'(DATAX_W'(mem_q_reg)) : '0;
            m_slot_index_reg <= OIDX_W'(IDXX_W'(res_idx_reg));
            m_tag_reg        <= res_tag_reg;
            m_was_empty_reg  <= res_empty_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data_out   = m_data_out_reg;
    assign m_slot_index = m_slot_index_reg;
    assign m_tag        = m_tag_reg;
    assign m_was_empty  = m_was_empty_reg;

endmodule

`default_nettype wire
